// ===== rtl/frbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frbs_pkg
// Shared types, widths, codes and the overlap function of the frame rate
// blend scheduler.
// ----------------------------------------------------------------------------
package frbs_pkg;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WW  = WEIGHT_FRAC_BITS + 1;        // weight / sum width
  localparam int CW  = 32;                          // frame counters
  localparam int RW  = 16;                          // rate registers
  localparam int LW  = 2 * RW;                      // frame span P or Q
  localparam int XW  = CW + LW;                     // count * span
  localparam int EW  = XW + 2;                      // doubled edge times
  localparam int DW  = LW + 1;                      // divisor 2*Q
  localparam int KW  = $clog2(WEIGHT_FRAC_BITS + 1);
  localparam int WEPS = (1 << WEIGHT_FRAC_BITS) / 100000;

  localparam logic [WW-1:0] WONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  // register map (word index)
  localparam logic [2:0] REG_SRC_NUM = 3'd0;
  localparam logic [2:0] REG_SRC_DEN = 3'd1;
  localparam logic [2:0] REG_DST_NUM = 3'd2;
  localparam logic [2:0] REG_DST_DEN = 3'd3;
  localparam logic [2:0] REG_MODE    = 3'd4;

  // interlace modes and line selects
  localparam logic [1:0] MODE_PROG = 2'd0;
  localparam logic [1:0] MODE_TFF  = 2'd1;
  localparam logic [1:0] MODE_BFF  = 2'd2;
  localparam logic [1:0] LINES_EVEN = 2'd1;
  localparam logic [1:0] LINES_ODD  = 2'd2;

  // multiplier operand select, in issue order
  localparam logic [1:0] MUL_PC = 2'd0;
  localparam logic [1:0] MUL_FC = 2'd1;
  localparam logic [1:0] MUL_DC = 2'd2;

  typedef struct packed {
    logic [RW-1:0] src_num;
    logic [RW-1:0] src_den;
    logic [RW-1:0] dst_num;
    logic [RW-1:0] dst_den;
    logic [1:0]    mode;
  } cfg_t;

  typedef struct packed {
    logic          ld_span;
    logic          mul_en;
    logic [1:0]    mul_sel;
    logic          edge_en;
    logic          ovl_en;
    logic          div_load;
    logic          div_fld;
    logic          div_step;
    logic          save_p;
    logic          commit;
    logic          clear;
  } cmd_t;

  typedef struct packed {
    logic          hit;
    logic          full;
    logic [DW-1:0] num;
  } ovl_t;

  typedef struct packed {
    logic          primary_mix;
    logic [WW-1:0] primary_weight;
    logic [1:0]    primary_lines;
    logic          field_mix;
    logic [WW-1:0] field_weight;
    logic [1:0]    field_lines;
    logic          emit_frame;
    logic          fetch_primary;
    logic          primary_from_field;
    logic          fetch_field;
    logic          field_from_primary;
  } res_t;

  // overlap of source span [ss,se) with destination span [ds,de)
  function automatic ovl_t overlap(input logic [EW-1:0] ss, input logic [EW-1:0] se,
                                   input logic [EW-1:0] ds, input logic [EW-1:0] de);
    ovl_t          r;
    logic [EW-1:0] d;
    r = '0;
    d = '0;
    if (ss > ds && se < de) begin
      d = se - ss;
    end else if (ss <= ds && se < de && se >= ds) begin
      d = se - ds;
    end else if (ss > ds && se >= de && ss <= de) begin
      d = de - ss;
    end else if (ss <= ds && se >= de) begin
      r.full = 1'b1;
    end
    r.num = d[DW-1:0];
    r.hit = r.full | (d != '0);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/frbs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frbs interfaces
// Tick input channel and schedule result channel.
// ----------------------------------------------------------------------------
interface frbs_tick_if;
  logic valid;
  logic ready;
  logic restart;
  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

interface frbs_sched_if;
  logic                        valid;
  logic                        ready;
  logic                        primary_mix;
  logic [frbs_pkg::WW-1:0]     primary_weight;
  logic [1:0]                  primary_lines;
  logic                        field_mix;
  logic [frbs_pkg::WW-1:0]     field_weight;
  logic [1:0]                  field_lines;
  logic                        emit_frame;
  logic                        fetch_primary;
  logic                        primary_from_field;
  logic                        fetch_field;
  logic                        field_from_primary;
  modport source(output valid, input ready, output primary_mix, primary_weight,
                 primary_lines, field_mix, field_weight, field_lines, emit_frame,
                 fetch_primary, primary_from_field, fetch_field, field_from_primary);
  modport sink(input valid, output ready, input primary_mix, primary_weight,
               primary_lines, field_mix, field_weight, field_lines, emit_frame,
               fetch_primary, primary_from_field, fetch_field, field_from_primary);
endinterface
`default_nettype wire

// ===== rtl/frbs_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frbs_cfg
// APB register file for the rate and interlace registers.
// ----------------------------------------------------------------------------
module frbs_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output frbs_pkg::cfg_t     cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_num <= frbs_pkg::RW'(25);
      cfg.src_den <= frbs_pkg::RW'(1);
      cfg.dst_num <= frbs_pkg::RW'(25);
      cfg.dst_den <= frbs_pkg::RW'(1);
      cfg.mode    <= frbs_pkg::MODE_PROG;
    end else if (wr) begin
      case (idx)
        frbs_pkg::REG_SRC_NUM: cfg.src_num <= pwdata[frbs_pkg::RW-1:0];
        frbs_pkg::REG_SRC_DEN: cfg.src_den <= pwdata[frbs_pkg::RW-1:0];
        frbs_pkg::REG_DST_NUM: cfg.dst_num <= pwdata[frbs_pkg::RW-1:0];
        frbs_pkg::REG_DST_DEN: cfg.dst_den <= pwdata[frbs_pkg::RW-1:0];
        frbs_pkg::REG_MODE:    cfg.mode    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      frbs_pkg::REG_SRC_NUM: prdata = 32'(cfg.src_num);
      frbs_pkg::REG_SRC_DEN: prdata = 32'(cfg.src_den);
      frbs_pkg::REG_DST_NUM: prdata = 32'(cfg.dst_num);
      frbs_pkg::REG_DST_DEN: prdata = 32'(cfg.dst_den);
      frbs_pkg::REG_MODE:    prdata = 32'(cfg.mode);
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/frbs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frbs_ctrl
// Sequencer: span setup, three products, edges, overlap, two divides, commit.
// ----------------------------------------------------------------------------
module frbs_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_restart,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output frbs_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SPAN = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_EDGE = 8'b0000_1000,
    S_OVL  = 8'b0001_0000,
    S_DIVP = 8'b0010_0000,
    S_DIVF = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  localparam logic [frbs_pkg::KW-1:0] CNT_LAST = frbs_pkg::KW'(frbs_pkg::WEIGHT_FRAC_BITS);
  localparam logic [frbs_pkg::KW-1:0] MUL_LAST = frbs_pkg::KW'(2);

  state_t                   state, state_next;
  logic [frbs_pkg::KW-1:0]  cnt, cnt_next;
  logic                     rs_flag, rs_flag_next;
  logic                     fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rs_flag_next = rs_flag;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          rs_flag_next = in_restart;
          state_next   = in_restart ? S_FIN : S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.ld_span = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt[1:0];    // PC, FC, DC in turn
        cnt_next    = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_en = 1'b1;
        state_next  = S_OVL;
      end
      S_OVL: begin
        cmd.ovl_en = 1'b1;
        state_next = S_DIVP;
      end
      S_DIVP: begin
        cmd.div_load = (cnt == '0);
        cmd.div_step = (cnt != '0);
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = S_DIVF;
        end
      end
      S_DIVF: begin
        cmd.div_fld  = 1'b1;
        cmd.div_load = (cnt == '0);
        cmd.save_p   = (cnt == '0);
        cmd.div_step = (cnt != '0);
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fire) begin
          cmd.commit   = 1'b1;
          cmd.clear    = rs_flag;
          rs_flag_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rs_flag   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rs_flag <= rs_flag_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frbs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frbs_dp
// Counters, sums, span multiplier, edge times, overlap and serial divider.
// ----------------------------------------------------------------------------
module frbs_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire frbs_pkg::cfg_t cfg,
  input  wire frbs_pkg::cmd_t cmd,
  output frbs_pkg::res_t     res
);

  localparam int F = frbs_pkg::WEIGHT_FRAC_BITS;

  logic [frbs_pkg::CW-1:0] pc, fc, dc;
  logic [frbs_pkg::WW-1:0] psum, fsum;
  logic [frbs_pkg::LW-1:0] p_len, q_len;
  logic [frbs_pkg::XW-1:0] x_pc, x_fc, x_dc;
  logic [frbs_pkg::EW-1:0] ss_p, se_p, ds_p, de_p, ss_f, se_f, ds_f, de_f;
  frbs_pkg::ovl_t          ovl_p, ovl_f;
  logic                    ge_p, le_p, ge_f, le_f;
  logic [frbs_pkg::DW-1:0] rem;
  logic [F-1:0]            quo, wp_q;

  // span setup, zero acts as one
  logic [frbs_pkg::RW-1:0] sn, sd, dn, dd;
  assign sn = (cfg.src_num == '0) ? frbs_pkg::RW'(1) : cfg.src_num;
  assign sd = (cfg.src_den == '0) ? frbs_pkg::RW'(1) : cfg.src_den;
  assign dn = (cfg.dst_num == '0) ? frbs_pkg::RW'(1) : cfg.dst_num;
  assign dd = (cfg.dst_den == '0) ? frbs_pkg::RW'(1) : cfg.dst_den;

  // shared 32x32 multiplier
  logic [frbs_pkg::CW-1:0] mul_a;
  logic [frbs_pkg::LW-1:0] mul_b;
  logic [frbs_pkg::XW-1:0] mul_y;
  always_comb begin
    case (cmd.mul_sel)
      frbs_pkg::MUL_PC: begin mul_a = pc; mul_b = p_len; end
      frbs_pkg::MUL_FC: begin mul_a = fc; mul_b = p_len; end
      frbs_pkg::MUL_DC: begin mul_a = dc; mul_b = q_len; end
      default:          begin mul_a = dc; mul_b = q_len; end
    endcase
  end
  assign mul_y = frbs_pkg::XW'(mul_a) * frbs_pkg::XW'(mul_b);

  // edge times, all doubled
  logic [frbs_pkg::EW-1:0] p1, p2, p3, q1, q2, q3, xp2, xf2, xd2;
  assign p1  = frbs_pkg::EW'(p_len);
  assign p2  = frbs_pkg::EW'({p_len, 1'b0});
  assign p3  = p1 + p2;
  assign q1  = frbs_pkg::EW'(q_len);
  assign q2  = frbs_pkg::EW'({q_len, 1'b0});
  assign q3  = q1 + q2;
  assign xp2 = frbs_pkg::EW'({x_pc, 1'b0});
  assign xf2 = frbs_pkg::EW'({x_fc, 1'b0});
  assign xd2 = frbs_pkg::EW'({x_dc, 1'b0});

  // divider: (num << F) / (2*Q), one quotient bit per step
  logic [frbs_pkg::DW-1:0] dvs;
  logic [frbs_pkg::DW:0]   rem_sh, rem_sub;
  assign dvs     = {q_len, 1'b0};
  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.ld_span) begin
      p_len <= frbs_pkg::LW'(sd) * frbs_pkg::LW'(dn);
      q_len <= frbs_pkg::LW'(dd) * frbs_pkg::LW'(sn);
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        frbs_pkg::MUL_PC: x_pc <= mul_y;
        frbs_pkg::MUL_FC: x_fc <= mul_y;
        default:          x_dc <= mul_y;
      endcase
    end
    if (cmd.edge_en) begin
      ss_p <= xp2;
      se_p <= xp2 + p2;
      ds_p <= xd2;
      de_p <= xd2 + q2;
      ss_f <= xf2 + p1;
      se_f <= xf2 + p3;
      ds_f <= xd2 + q1;
      de_f <= xd2 + q3;
    end
    if (cmd.ovl_en) begin
      ovl_p <= frbs_pkg::overlap(ss_p, se_p, ds_p, de_p);
      ovl_f <= frbs_pkg::overlap(ss_f, se_f, ds_f, de_f);
      ge_p  <= se_p >= de_p;
      le_p  <= se_p <= de_p;
      ge_f  <= se_f >= de_f;
      le_f  <= se_f <= de_f;
    end
    if (cmd.div_load) begin
      rem <= cmd.div_fld ? ovl_f.num : ovl_p.num;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[frbs_pkg::DW]) begin
        rem <= rem_sub[frbs_pkg::DW-1:0];
        quo <= {quo[F-2:0], 1'b1};
      end else begin
        rem <= rem_sh[frbs_pkg::DW-1:0];
        quo <= {quo[F-2:0], 1'b0};
      end
    end
    if (cmd.save_p) begin
      wp_q <= quo;
    end
  end

  // commit of one step
  logic [1:0]              mode;
  logic                    ilace, p_issue, f_issue, emit, f_adv, p_adv, ffp, pff;
  logic [frbs_pkg::WW-1:0] wp, wf, psum_add, fsum_add;
  logic [frbs_pkg::CW-1:0] fc_inc;
  logic [frbs_pkg::WW:0]   p_room, f_room;

  assign mode   = (cfg.mode == frbs_pkg::MODE_TFF || cfg.mode == frbs_pkg::MODE_BFF)
                  ? cfg.mode : frbs_pkg::MODE_PROG;
  assign ilace  = (mode != frbs_pkg::MODE_PROG);
  assign wp     = ovl_p.full ? frbs_pkg::WONE : frbs_pkg::WW'(wp_q);
  assign wf     = ovl_f.full ? frbs_pkg::WONE : frbs_pkg::WW'(quo);
  // headroom to 1.0; a wrapped value reads as large, same as the unsigned model
  assign p_room = {1'b0, frbs_pkg::WONE} - {1'b0, psum};
  assign f_room = {1'b0, frbs_pkg::WONE} - {1'b0, fsum};
  assign p_issue = ovl_p.hit && (p_room > (frbs_pkg::WW+1)'(frbs_pkg::WEPS));
  assign f_issue = ilace && ovl_f.hit && (f_room > (frbs_pkg::WW+1)'(frbs_pkg::WEPS));
  assign emit   = ge_p && (!ilace || ge_f);
  assign f_adv  = !emit && ilace && le_f;
  assign ffp    = pc > fc;
  assign fc_inc = fc + (f_adv ? frbs_pkg::CW'(1) : '0);
  assign p_adv  = !emit && le_p;
  assign pff    = ilace && (pc < fc_inc);
  assign psum_add = psum + (p_issue ? wp : '0);
  assign fsum_add = fsum + (f_issue ? wf : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      fc   <= '0;
      dc   <= '0;
      psum <= '0;
      fsum <= '0;
    end else if (cmd.commit) begin
      if (cmd.clear) begin
        pc   <= '0;
        fc   <= '0;
        dc   <= '0;
        psum <= '0;
        fsum <= '0;
      end else begin
        pc   <= pc + (p_adv ? frbs_pkg::CW'(1) : '0);
        fc   <= fc_inc;
        dc   <= dc + (emit ? frbs_pkg::CW'(1) : '0);
        psum <= emit ? '0 : psum_add;
        fsum <= emit ? '0 : fsum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.clear) begin
        res <= '0;
      end else begin
        res.primary_mix        <= p_issue;
        res.primary_weight     <= p_issue ? wp : '0;
        res.primary_lines      <= p_issue ? mode : frbs_pkg::MODE_PROG;
        res.field_mix          <= f_issue;
        res.field_weight       <= f_issue ? wf : '0;
        res.field_lines        <= !f_issue ? 2'b00 :
                                  (mode == frbs_pkg::MODE_TFF) ? frbs_pkg::LINES_ODD
                                                               : frbs_pkg::LINES_EVEN;
        res.emit_frame         <= emit;
        res.field_from_primary <= f_adv && ffp;
        res.fetch_field        <= f_adv && !ffp;
        res.primary_from_field <= p_adv && pff;
        res.fetch_primary      <= p_adv && !pff;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frame_rate_blend_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_rate_blend_scheduler_unit
// Scheduler of a time-overlap blending frame-rate converter.
// ----------------------------------------------------------------------------
// Each tick beat advances the converter by one step and yields one schedule
// beat: Q1.16 overlap weights for the primary frame and the opposite field,
// line selects, the emit flag and the buffer fetch/copy requests. A restart
// tick clears the counters and sums and returns an all-zero beat. A normal
// tick runs through span setup, three products on one shared 32x32
// multiplier, edge times, overlap and end compares, then two restoring
// divides (load plus one quotient bit per cycle) and the commit. A restart
// tick goes straight to the commit. The next tick can be taken in the same
// cycle as the result is presented. One tick is in work at a time; the
// result sits in an output register, so a new tick is taken while the
// previous beat is still waiting, and its commit waits until that beat is
// taken. Configure the rate and interlace registers over APB only while
// the block is idle. Zero rate values act as one; interlace code 3 acts as
// progressive.
// ----------------------------------------------------------------------------
module frame_rate_blend_scheduler_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  frbs_tick_if.sink         tick,
  frbs_sched_if.source      sched,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  frbs_pkg::cfg_t cfg;
  frbs_pkg::cmd_t cmd;
  frbs_pkg::res_t res;

  assign pready = 1'b1;

  frbs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  frbs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tick.valid),
    .in_restart (tick.restart),
    .in_ready   (tick.ready),
    .out_valid  (sched.valid),
    .out_ready  (sched.ready),
    .cmd        (cmd)
  );

  frbs_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .res (res)
  );

  // result register fans out onto the schedule channel
  assign sched.primary_mix        = res.primary_mix;
  assign sched.primary_weight     = res.primary_weight;
  assign sched.primary_lines      = res.primary_lines;
  assign sched.field_mix          = res.field_mix;
  assign sched.field_weight       = res.field_weight;
  assign sched.field_lines        = res.field_lines;
  assign sched.emit_frame         = res.emit_frame;
  assign sched.fetch_primary      = res.fetch_primary;
  assign sched.primary_from_field = res.primary_from_field;
  assign sched.fetch_field        = res.fetch_field;
  assign sched.field_from_primary = res.field_from_primary;

endmodule
`default_nettype wire

// ===== tb/tb_frame_rate_blend_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_frame_rate_blend_scheduler_unit
// Self-checking bench for the frame rate blend scheduler. Tick beats go in,
// and a local schedule predictor works out the expected beat at each accept.
// The runs cover default rates, zero and extreme rate values, every interlace
// mode and a long random part over random rate settings, with both sides
// idling at random.
// ----------------------------------------------------------------------------
module tb_frame_rate_blend_scheduler_unit;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frbs_tick_if  tick_if();
  frbs_sched_if sched_if();

  frame_rate_blend_scheduler_unit u_top (
    .clk(clk), .rst(rst), .tick(tick_if.sink), .sched(sched_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // predictor state: rate registers, counters, running sums
  logic [15:0]     rate_src_num, rate_src_den, rate_dst_num, rate_dst_den;
  logic [1:0]      lace_mode;
  logic [31:0]     src_frame, fld_frame, dst_frame;
  longint unsigned prim_sum, fld_sum;

  frbs_pkg::res_t sched_expect_q[$];
  int     errors = 0;
  int     beats_checked = 0;
  int     emits_seen = 0;
  int     cycle_cnt = 0;
  bit     idle_on = 1'b0;

  initial begin
    tick_if.valid   = 1'b0;
    tick_if.restart = 1'b0;
    sched_if.ready  = 1'b0;
  end

  function automatic logic [127:0] nz16(logic [15:0] v);
    return (v == 16'd0) ? 128'd1 : {112'd0, v};
  endfunction

  // overlap weight of source span starting at doubled index a against the
  // destination span starting at doubled index b
  function automatic longint unsigned blend_weight(logic [127:0] a, logic [127:0] b,
                                                   logic [127:0] sp, logic [127:0] sq,
                                                   output bit hit);
    logic [127:0] ss, se, ds, de, num;
    ss = a * sp;
    se = (a + 128'd2) * sp;
    ds = b * sq;
    de = (b + 128'd2) * sq;
    num = '0;
    hit = 1'b0;
    if (ss > ds && se < de) begin
      num = se - ss;
    end else if (ss <= ds && se < de && se >= ds) begin
      num = se - ds;
    end else if (ss > ds && se >= de && ss <= de) begin
      num = de - ss;
    end else if (ss <= ds && se >= de) begin
      hit = 1'b1;
      return 64'd65536;
    end
    if (num == '0) return 64'd0;
    hit = 1'b1;
    return longint'((num << frbs_pkg::WEIGHT_FRAC_BITS) / (sq * 128'd2));
  endfunction

  // compare frame end (2*s+k)*P against (2*d+k)*Q: -1, 0, 1
  function automatic int end_order(logic [31:0] s, logic [31:0] d, int k,
                                   logic [127:0] sp, logic [127:0] sq);
    logic [127:0] l, r;
    l = (128'd2 * s + k) * sp;
    r = (128'd2 * d + k) * sq;
    return (l < r) ? -1 : (l > r) ? 1 : 0;
  endfunction

  function automatic frbs_pkg::res_t schedule_step(bit rs);
    frbs_pkg::res_t  r;
    logic [1:0]      m;
    bit              il, hit;
    longint unsigned w;
    logic [127:0]    sp, sq;
    int              pe, fe;
    r = '0;
    if (rs) begin
      src_frame = '0; fld_frame = '0; dst_frame = '0;
      prim_sum = 0; fld_sum = 0;
      return r;
    end
    m  = (lace_mode == 2'd3) ? frbs_pkg::MODE_PROG : lace_mode;
    il = (m != frbs_pkg::MODE_PROG);
    sp = nz16(rate_src_den) * nz16(rate_dst_num);
    sq = nz16(rate_dst_den) * nz16(rate_src_num);

    w = blend_weight(128'd2 * src_frame, 128'd2 * dst_frame, sp, sq, hit);
    if (hit && (64'd65536 - prim_sum) > frbs_pkg::WEPS) begin
      r.primary_mix    = 1'b1;
      r.primary_weight = w[frbs_pkg::WW-1:0];
      r.primary_lines  = m;
      prim_sum += w;
    end
    if (il) begin
      w = blend_weight(128'd2 * fld_frame + 1, 128'd2 * dst_frame + 1, sp, sq, hit);
      if (hit && (64'd65536 - fld_sum) > frbs_pkg::WEPS) begin
        r.field_mix    = 1'b1;
        r.field_weight = w[frbs_pkg::WW-1:0];
        r.field_lines  = (m == frbs_pkg::MODE_TFF) ? frbs_pkg::LINES_ODD
                                                   : frbs_pkg::LINES_EVEN;
        fld_sum += w;
      end
    end

    pe = end_order(src_frame, dst_frame, 2, sp, sq);
    fe = end_order(fld_frame, dst_frame, 3, sp, sq);
    if (pe >= 0 && (!il || fe >= 0)) begin
      r.emit_frame = 1'b1;
      prim_sum = 0; fld_sum = 0;
      dst_frame++;
    end else begin
      if (il && fe <= 0) begin
        if (src_frame > fld_frame) r.field_from_primary = 1'b1;
        else r.fetch_field = 1'b1;
        fld_frame++;
      end
      if (pe <= 0) begin
        if (il && src_frame < fld_frame) r.primary_from_field = 1'b1;
        else r.fetch_primary = 1'b1;
        src_frame++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    errors++;
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_checked, what, got, exp);
  endtask

  // --- result checking at the rising edge ---
  always @(posedge clk) begin
    frbs_pkg::res_t g, e;
    if (!rst && sched_if.valid && sched_if.ready) begin
      g = '{sched_if.primary_mix, sched_if.primary_weight, sched_if.primary_lines,
            sched_if.field_mix, sched_if.field_weight, sched_if.field_lines,
            sched_if.emit_frame, sched_if.fetch_primary, sched_if.primary_from_field,
            sched_if.fetch_field, sched_if.field_from_primary};
      if (sched_expect_q.size() == 0) begin
        report_mismatch("unexpected beats queued", 1, 0);
      end else begin
        e = sched_expect_q.pop_front();
        if (g.primary_mix != e.primary_mix)
          report_mismatch("primary_mix", g.primary_mix, e.primary_mix);
        if (g.primary_weight != e.primary_weight)
          report_mismatch("primary_weight", g.primary_weight, e.primary_weight);
        if (g.primary_lines != e.primary_lines)
          report_mismatch("primary_lines", g.primary_lines, e.primary_lines);
        if (g.field_mix != e.field_mix)
          report_mismatch("field_mix", g.field_mix, e.field_mix);
        if (g.field_weight != e.field_weight)
          report_mismatch("field_weight", g.field_weight, e.field_weight);
        if (g.field_lines != e.field_lines)
          report_mismatch("field_lines", g.field_lines, e.field_lines);
        if (g.emit_frame != e.emit_frame)
          report_mismatch("emit_frame", g.emit_frame, e.emit_frame);
        if (g.fetch_primary != e.fetch_primary)
          report_mismatch("fetch_primary", g.fetch_primary, e.fetch_primary);
        if (g.primary_from_field != e.primary_from_field)
          report_mismatch("primary_from_field", g.primary_from_field, e.primary_from_field);
        if (g.fetch_field != e.fetch_field)
          report_mismatch("fetch_field", g.fetch_field, e.fetch_field);
        if (g.field_from_primary != e.field_from_primary)
          report_mismatch("field_from_primary", g.field_from_primary, e.field_from_primary);
        if (e.emit_frame) emits_seen++;
      end
      beats_checked++;
    end
  end

  // result side backpressure, changed at the falling edge
  always @(negedge clk) begin
    sched_if.ready <= idle_on ? ($urandom_range(99) >= 8) : 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_frame_rate_blend_scheduler_unit: FAIL");
      $finish;
    end
  end

  // APB write: setup then access; pready is tied high
  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      frbs_pkg::REG_SRC_NUM: rate_src_num = val[15:0];
      frbs_pkg::REG_SRC_DEN: rate_src_den = val[15:0];
      frbs_pkg::REG_DST_NUM: rate_dst_num = val[15:0];
      frbs_pkg::REG_DST_DEN: rate_dst_den = val[15:0];
      frbs_pkg::REG_MODE:    lace_mode    = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_rates(int sn, int sd, int dn, int dd, int md);
    apb_write(frbs_pkg::REG_SRC_NUM, sn);
    apb_write(frbs_pkg::REG_SRC_DEN, sd);
    apb_write(frbs_pkg::REG_DST_NUM, dn);
    apb_write(frbs_pkg::REG_DST_DEN, dd);
    apb_write(frbs_pkg::REG_MODE, md);
  endtask

  // one tick beat; valid stays up into the next call when there is no gap
  task automatic send_tick(bit rs);
    int gap;
    gap = (idle_on && $urandom_range(99) < 8) ? $urandom_range(4, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      tick_if.valid <= 1'b0;
    end
    @(negedge clk);
    tick_if.valid   <= 1'b1;
    tick_if.restart <= rs;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    sched_expect_q.push_back(schedule_step(rs));
  endtask

  // idle the block: all beats back, then let a late tick settle
  task automatic drain;
    @(negedge clk);
    tick_if.valid <= 1'b0;
    while (sched_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_stream(int n);
    send_tick(1'b1);
    repeat (n) send_tick(1'b0);
    drain();
  endtask

  // default 25/25 progressive, then restart in mid stream
  task automatic test_defaults;
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();
  endtask

  // zero rates act as one, mode three acts as progressive, extreme ratios
  task automatic test_rate_extremes;
    set_rates(0, 0, 0, 0, 3);
    run_stream(3);
    set_rates(65535, 1, 1, 65535, 0);
    run_stream(3);
    set_rates(1, 65535, 65535, 1, 0);
    run_stream(3);
  endtask

  // top and bottom field first, with a rate step-down that needs copies
  task automatic test_interlace;
    set_rates(50, 1, 30, 1, frbs_pkg::MODE_TFF);
    run_stream(10);
    set_rates(24000, 1001, 60, 1, frbs_pkg::MODE_BFF);
    run_stream(10);
  endtask

  task automatic test_random;
    int n, sn, sd, dn, dd;
    for (int ph = 0; ph < 9; ph++) begin
      idle_on = (ph != 1);              // one phase with no idling at all
      if ($urandom_range(9) == 0) begin
        sn = $urandom_range(65535); sd = $urandom_range(65535);
        dn = $urandom_range(65535); dd = $urandom_range(65535);
      end else begin
        sn = $urandom_range(60, 1); sd = $urandom_range(3, 1);
        dn = $urandom_range(60, 1); dd = $urandom_range(3, 1);
      end
      set_rates(sn, sd, dn, dd, $urandom_range(3));
      send_tick(1'b1);
      n = 95;
      repeat (n) send_tick($urandom_range(99) < 3);
      drain();
    end
  endtask

  initial begin
    rate_src_num = 16'd25; rate_src_den = 16'd1;
    rate_dst_num = 16'd25; rate_dst_den = 16'd1;
    lace_mode = frbs_pkg::MODE_PROG;
    src_frame = '0; fld_frame = '0; dst_frame = '0;
    prim_sum = 0; fld_sum = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_rate_extremes();
    idle_on = 1'b1;
    test_interlace();
    test_random();

    $display("covered %0d schedule beats, %0d emits, over all interlace modes",
             beats_checked, emits_seen);
    $display("rate settings: defaults, zero, 1 and 65535 extremes, random ratios");
    if (errors == 0 && sched_expect_q.size() == 0) begin
      $display("tb_frame_rate_blend_scheduler_unit: PASS");
    end else begin
      $display("%0d mismatches, %0d beats missing", errors, sched_expect_q.size());
      $display("tb_frame_rate_blend_scheduler_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/frbs_pkg.sv
rtl/frbs_if.sv
rtl/frbs_cfg.sv
rtl/frbs_ctrl.sv
rtl/frbs_dp.sv
rtl/frame_rate_blend_scheduler_unit.sv
tb/tb_frame_rate_blend_scheduler_unit.sv
